[rtl/lws_pkg.sv]
// Shared types, codes and tables for the 4-bit LCD write sequencer.
`default_nettype none
package lws_pkg;

  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIMER_W   = 20;

  localparam logic [CFG_W-1:0] POWER_ON_RST = CFG_W'(50000);
  localparam logic [CFG_W-1:0] COMMAND_RST  = CFG_W'(39);
  localparam logic [CFG_W-1:0] CLEAR_RST    = CFG_W'(1530);
  localparam logic [CFG_W-1:0] ENABLE_RST   = CFG_W'(1000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POWER_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd3;

  // request codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_INIT   = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_CHAR   = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // status codes
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // byte write phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HIGH   = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_LOW    = 3'd3;
  localparam logic [2:0] PH_SETTLE = 3'd4;

  localparam logic [2:0] INIT_STEPS = 3'd5;

  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_HOME      = 8'h02;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_INIT  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [CFG_W-1:0] power_on;
    logic [CFG_W-1:0] command;
    logic [CFG_W-1:0] clear;
    logic [CFG_W-1:0] enable;
  } timers_t;

  typedef struct packed {
    logic [3:0] col;
    logic [1:0] row;
    logic [7:0] byte_value;
    logic [2:0] cmd;
  } item_t;

  typedef struct packed {
    logic       op_done;
    logic [1:0] status;
    logic       init_done;
    logic       busy_res;
    logic [3:0] nibble;
    logic       enable;
    logic       rw;
    logic       rs;
  } result_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    init_byte = LCD_HOME;
      3'd1:    init_byte = 8'h28;
      3'd2:    init_byte = 8'h0C;
      3'd3:    init_byte = 8'h06;
      default: init_byte = LCD_CLEAR;
    endcase
  endfunction

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    case (row)
      2'd0:    row_offset = 8'h00;
      2'd1:    row_offset = 8'h40;
      2'd2:    row_offset = 8'h10;
      default: row_offset = 8'h50;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/lws_cfg_regs.sv]
// Timing configuration registers of the LCD write sequencer.
`default_nettype none
module lws_cfg_regs
  import lws_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output timers_t                   timers_o
);

  timers_t timers_q, timers_d;

  always_comb begin
    timers_d = timers_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POWER_ON: timers_d.power_on = cfg_data_i;
        REG_COMMAND:  timers_d.command  = cfg_data_i;
        REG_CLEAR:    timers_d.clear    = cfg_data_i;
        REG_ENABLE:   timers_d.enable   = cfg_data_i;
        default:      timers_d = timers_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timers_q.power_on <= POWER_ON_RST;
      timers_q.command  <= COMMAND_RST;
      timers_q.clear    <= CLEAR_RST;
      timers_q.enable   <= ENABLE_RST;
    end else begin
      timers_q <= timers_d;
    end
  end

  assign timers_o = timers_q;

endmodule
`default_nettype wire

[rtl/lws_seq.sv]
// Operation state machine, tick timer and bus drive of the LCD write sequencer.
`default_nettype none
module lws_seq
  import lws_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_W
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  input  wire timers_t timers_i,
  output result_t      result_o
);

  localparam int unsigned CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  function automatic logic [TIMER_WIDTH-1:0] load(input logic [CFG_W-1:0] v);
    logic [CW-1:0] ext;
    logic [CW-1:0] lim;
    ext = CW'(v);
    lim = CW'({TIMER_WIDTH{1'b1}});
    load = (ext > lim) ? {TIMER_WIDTH{1'b1}} : ext[TIMER_WIDTH-1:0];
  endfunction

  op_e                    op_q, op_d;
  logic [2:0]             step_q, step_d;
  logic [2:0]             phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] cnt_q, cnt_d;
  logic [7:0]             byte_q, byte_d;
  logic                   rs_q, rs_d;
  logic                   en_q, en_d;
  logic [3:0]             nib_q, nib_d;
  logic                   init_q, init_d;

  logic       busy;
  logic       start;
  logic [7:0] start_byte;
  logic       start_rs;
  logic       fin;
  logic [1:0] status;
  logic [7:0] cursor_byte;

  assign busy        = (op_q != OP_IDLE);
  assign cursor_byte = ({4'h0, item_i.col} + row_offset(item_i.row)) | LCD_SET_DDRAM;

  always_comb begin
    op_d       = op_q;
    step_d     = step_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    byte_d     = byte_q;
    rs_d       = rs_q;
    en_d       = en_q;
    nib_d      = nib_q;
    init_d     = init_q;
    start      = 1'b0;
    start_byte = byte_q;
    start_rs   = 1'b0;
    fin        = 1'b0;
    status     = ST_NONE;

    if (step_i) begin
      case (item_i.cmd)
        CMD_TICK: begin
          if (busy) begin
            if (cnt_q > TIMER_WIDTH'(1)) begin
              cnt_d = cnt_q - TIMER_WIDTH'(1);
            end else begin
              cnt_d = '0;
              if (op_q == OP_INIT && step_q == 3'd0) begin
                step_d     = 3'd1;
                start      = 1'b1;
                start_byte = init_byte(3'd0);
              end else begin
                case (phase_q)
                  PH_HIGH: begin
                    en_d    = 1'b0;
                    nib_d   = byte_q[3:0];
                    phase_d = PH_GAP;
                  end
                  PH_GAP: begin
                    en_d    = 1'b1;
                    cnt_d   = load(timers_i.enable);
                    phase_d = PH_LOW;
                  end
                  PH_LOW: begin
                    en_d = 1'b0;
                    if (op_q == OP_WRITE) begin
                      fin = 1'b1;
                    end else begin
                      cnt_d = (op_q == OP_CLEAR || step_q >= INIT_STEPS)
                              ? load(timers_i.clear) : load(timers_i.command);
                      phase_d = PH_SETTLE;
                    end
                  end
                  default: begin
                    if (op_q == OP_INIT && step_q != 3'd0 && step_q < INIT_STEPS) begin
                      step_d     = step_q + 3'd1;
                      start      = 1'b1;
                      start_byte = init_byte(step_q);
                    end else begin
                      fin = 1'b1;
                    end
                  end
                endcase
              end
            end
          end
        end
        CMD_INIT: begin
          if (busy) begin
            status = ST_REJECT;
          end else begin
            status  = ST_ACCEPT;
            op_d    = OP_INIT;
            init_d  = 1'b0;
            step_d  = 3'd0;
            phase_d = PH_IDLE;
            en_d    = 1'b0;
            rs_d    = 1'b0;
            cnt_d   = load(timers_i.power_on);
          end
        end
        CMD_WRITE, CMD_CHAR, CMD_CURSOR, CMD_CLEAR: begin
          if (busy) begin
            status = ST_REJECT;
          end else begin
            status = ST_ACCEPT;
            start  = 1'b1;
            op_d   = (item_i.cmd == CMD_CLEAR) ? OP_CLEAR : OP_WRITE;
            case (item_i.cmd)
              CMD_CHAR: begin
                start_byte = item_i.byte_value;
                start_rs   = 1'b1;
              end
              CMD_CURSOR: start_byte = cursor_byte;
              CMD_CLEAR:  start_byte = LCD_CLEAR;
              default:    start_byte = item_i.byte_value;
            endcase
          end
        end
        default: ;
      endcase

      if (fin) begin
        if (op_q == OP_INIT) begin
          init_d = 1'b1;
          step_d = 3'd0;
        end
        op_d    = OP_IDLE;
        phase_d = PH_IDLE;
        cnt_d   = '0;
        en_d    = 1'b0;
      end

      if (start) begin
        byte_d  = start_byte;
        rs_d    = start_rs;
        nib_d   = start_byte[7:4];
        en_d    = 1'b1;
        cnt_d   = load(timers_i.enable);
        phase_d = PH_HIGH;
      end
    end

    result_o.rs        = rs_d;
    result_o.rw        = 1'b0;
    result_o.enable    = en_d;
    result_o.nibble    = nib_d;
    result_o.busy_res  = (op_d != OP_IDLE);
    result_o.init_done = init_d;
    result_o.status    = status;
    result_o.op_done   = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      step_q  <= 3'd0;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      byte_q  <= 8'h00;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
      nib_q   <= 4'h0;
      init_q  <= 1'b0;
    end else begin
      op_q    <= op_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      byte_q  <= byte_d;
      rs_q    <= rs_d;
      en_q    <= en_d;
      nib_q   <= nib_d;
      init_q  <= init_d;
    end
  end

endmodule
`default_nettype wire

[rtl/lcd_4bit_write_sequencer_top.sv]
// Top level of the 4-bit LCD write sequencer: stream ports, input and result registers.
// A request lands in the input register; its result is loaded into the result register when it advances.
// Throughput: one request per cycle unless m_axis_tready holds the result; timer and sequencer step once per request.
// Reset (rst_ni low, asynchronous): sequencer idle, bus and flags cleared, timing
// registers back to 50000 / 39 / 1530 / 1000 ticks, both register stages empty.
`default_nettype none
module lcd_4bit_write_sequencer_top
  import lws_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // [2:0] cmd, [10:3] byte_value, [12:11] row, [16:13] col, [23:17] ignored
  input  wire logic [23:0]          s_axis_tdata,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] rs, [1] rw, [2] enable, [6:3] nibble, [7] busy_res, [8] init_done,
  // [10:9] status, [11] op_done, [15:12] zero
  output      logic [15:0]          m_axis_tdata,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(result_t);

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;
  logic    s_fire;
  timers_t timers;
  result_t result;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  lws_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .timers_o    (timers)
  );

  lws_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .timers_i (timers),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= item_t'(s_axis_tdata[ITEM_W-1:0]);
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - RES_W)'(0), out_q};

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after a request advanced");

  a_idle_enable_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.busy_res |-> !out_q.enable)
    else $error("enable high while sequencer idle");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.op_done |-> !out_q.busy_res && out_q.status == ST_NONE)
    else $error("operation done while still busy");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_REJECT |-> out_q.busy_res)
    else $error("request rejected while idle");

endmodule
`default_nettype wire
